/* design/assert_macros.svh */
// Assertion macros for the design files; only odometry_pose_integrator includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* design/opi_pkg.sv */
`default_nettype none

package opi_pkg;

    localparam int ANGLE_BITS = 32;
    localparam int STEPS      = ANGLE_BITS - 2;
    localparam int STEP_W     = $clog2(STEPS);

    localparam int POS_W  = 48;
    localparam int ACC_W  = POS_W + 2;
    localparam int ROT_W  = 49;
    localparam int ANG_W  = 34;
    localparam int IN_W   = 32;

    localparam logic signed [31:0] GAIN_Q31 = 32'sd1304065748;
    localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    localparam logic [2:0] REG_POS_DB    = 3'd0;
    localparam logic [2:0] REG_HEAD_DB   = 3'd1;
    localparam logic [2:0] REG_START_X   = 3'd2;
    localparam logic [2:0] REG_START_Y   = 3'd3;
    localparam logic [2:0] REG_START_HDG = 3'd4;

    localparam logic [15:0] POS_DB_RESET  = 16'd7;
    localparam logic [31:0] HEAD_DB_RESET = 32'd6835;

    typedef struct packed {
        logic [15:0]        position_dead_band;
        logic [31:0]        heading_dead_band;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic [31:0]        start_heading;
    } cfg_t;

    typedef struct packed {
        logic              latch;
        logic              load_start;
        logic              head;
        logic              mul_f;
        logic              mul_l;
        logic              quad;
        logic              rot;
        logic              acc;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic still;
    } sts_t;

    // Arctangent of 2^-i in 2^-32 turns.
    function automatic logic [29:0] atan_turns(input logic [4:0] idx);
        logic [29:0] r;
        unique case (idx)
            5'd0:  r = 30'd536870912;
            5'd1:  r = 30'd316933406;
            5'd2:  r = 30'd167458907;
            5'd3:  r = 30'd85004756;
            5'd4:  r = 30'd42667331;
            5'd5:  r = 30'd21354465;
            5'd6:  r = 30'd10680862;
            5'd7:  r = 30'd5340245;
            5'd8:  r = 30'd2670163;
            5'd9:  r = 30'd1335087;
            5'd10: r = 30'd667544;
            5'd11: r = 30'd333772;
            5'd12: r = 30'd166886;
            5'd13: r = 30'd83443;
            5'd14: r = 30'd41722;
            5'd15: r = 30'd20861;
            5'd16: r = 30'd10430;
            5'd17: r = 30'd5215;
            5'd18: r = 30'd2608;
            5'd19: r = 30'd1304;
            5'd20: r = 30'd652;
            5'd21: r = 30'd326;
            5'd22: r = 30'd163;
            5'd23: r = 30'd81;
            5'd24: r = 30'd41;
            5'd25: r = 30'd20;
            5'd26: r = 30'd10;
            5'd27: r = 30'd5;
            5'd28: r = 30'd3;
            5'd29: r = 30'd1;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/odometry_pose_integrator.sv */
// Channel   Direction  Word contents
// s_axis    in         tuser: op; tdata: delta_forward, delta_lateral, delta_heading
// m_axis    out        tdata: pose_x, pose_y, pose_heading, moved, saturated
// cfg       in         cfg_index selects the register, cfg_data holds the value
//
// A moving word passes through decode, heading add, two gain multiplies on one
// shared multiplier, quadrant fold, ANGLE_BITS-2 CORDIC iterations, accumulate, emit.
// A reload or a word inside the dead bands goes from decode straight to emit.
// A new input word is taken while the previous result waits in the output register.
// Reset clears the pose to zero and the registers to their defaults.
`default_nettype none
`include "assert_macros.svh"

module odometry_pose_integrator (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,  // delta_forward, delta_lateral, delta_heading
    input  wire logic         s_tuser,  // op
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [135:0]      m_tdata,  // pose_x, pose_y, pose_heading, moved, saturated
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);
    import opi_pkg::*;

    cfg_t           cfg_reg;
    cmd_t           cmd;
    sts_t           sts;
    logic           emit;
    logic           out_free;
    logic           m_tvalid_reg;
    logic [135:0]   m_tdata_reg;
    logic signed [47:0] pose_x, pose_y;
    logic [31:0]    pose_heading;
    logic           moved, saturated;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.position_dead_band <= POS_DB_RESET;
            cfg_reg.heading_dead_band  <= HEAD_DB_RESET;
            cfg_reg.start_x            <= '0;
            cfg_reg.start_y            <= '0;
            cfg_reg.start_heading      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POS_DB:    cfg_reg.position_dead_band <= cfg_data[15:0];
                REG_HEAD_DB:   cfg_reg.heading_dead_band  <= cfg_data;
                REG_START_X:   cfg_reg.start_x            <= cfg_data;
                REG_START_Y:   cfg_reg.start_y            <= cfg_data;
                REG_START_HDG: cfg_reg.start_heading      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    opi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd),
        .emit     (emit)
    );

    opi_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .sts          (sts),
        .in_op        (s_tuser),
        .in_forward   (s_tdata[31:0]),
        .in_lateral   (s_tdata[63:32]),
        .in_heading   (s_tdata[95:64]),
        .pose_x       (pose_x),
        .pose_y       (pose_y),
        .pose_heading (pose_heading),
        .moved        (moved),
        .saturated    (saturated)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (emit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            m_tdata_reg <= {6'd0, saturated, moved, pose_heading, pose_y, pose_x};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `ASSERT_IMPL(a_sat_needs_motion, clk, rst_n, m_tvalid, !m_tdata[129] || m_tdata[128])
    `ASSERT_IMPL(a_emit_has_room, clk, rst_n, emit, out_free)

endmodule

`default_nettype wire

/* design/opi_ctrl.sv */
`default_nettype none

module opi_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          out_free,
    input  wire opi_pkg::sts_t sts,
    output opi_pkg::cmd_t      cmd,
    output logic               emit
);
    import opi_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECIDE = 9'b000000010,
        S_HEAD   = 9'b000000100,
        S_MULF   = 9'b000001000,
        S_MULL   = 9'b000010000,
        S_QUAD   = 9'b000100000,
        S_ROT    = 9'b001000000,
        S_ACC    = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        emit       = 1'b0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.op)
                begin
                    cmd.load_start = 1'b1;
                    state_next     = S_DONE;
                end
                else if (sts.still)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                cmd.head   = 1'b1;
                state_next = S_MULF;
            end
            S_MULF:
            begin
                cmd.mul_f  = 1'b1;
                state_next = S_MULL;
            end
            S_MULL:
            begin
                cmd.mul_l  = 1'b1;
                state_next = S_QUAD;
            end
            S_QUAD:
            begin
                cmd.quad   = 1'b1;
                step_next  = '0;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                cmd.rot = 1'b1;
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    state_next = S_ACC;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/opi_datapath.sv */
`default_nettype none

module opi_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire opi_pkg::cfg_t      cfg,
    input  wire opi_pkg::cmd_t      cmd,
    output opi_pkg::sts_t           sts,
    input  wire logic               in_op,
    input  wire logic signed [31:0] in_forward,
    input  wire logic signed [31:0] in_lateral,
    input  wire logic signed [31:0] in_heading,
    output logic signed [47:0]      pose_x,
    output logic signed [47:0]      pose_y,
    output logic [31:0]             pose_heading,
    output logic                    moved,
    output logic                    saturated
);
    import opi_pkg::*;

    logic                    op_reg;
    logic signed [IN_W-1:0]  f_reg, l_reg, dh_reg;
    logic signed [ROT_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ANG_W-1:0] z_reg, z_next;
    logic signed [POS_W-1:0] wx_reg, wx_next, wy_reg, wy_next;
    logic [31:0]             wh_reg, wh_next;
    logic                    moved_reg, moved_next, sat_reg, sat_next;

    logic [IN_W:0]           mag_f, mag_l, mag_h;
    logic signed [IN_W-1:0]  mul_a;
    logic signed [63:0]      prod, prod_rnd;
    logic signed [ROT_W-1:0] gained;
    logic [31:0]             hq, u;
    logic [1:0]              q;
    logic signed [ROT_W-1:0] sx, sy;
    logic signed [ANG_W-1:0] step_ang;
    logic signed [ROT_W-1:0] rx, ry;
    logic signed [ACC_W-1:0] sum_x, sum_y;
    logic                    ovf_x, ovf_y;
    logic signed [POS_W-1:0] cl_x, cl_y;

    function automatic logic [IN_W:0] magn(input logic signed [IN_W-1:0] v);
        logic signed [IN_W:0] e;
        e = {v[IN_W-1], v};
        return v[IN_W-1] ? (IN_W + 1)'(-e) : e;
    endfunction

    always_comb
    begin
        mag_f     = magn(f_reg);
        mag_l     = magn(l_reg);
        mag_h     = magn(dh_reg);
        sts.op    = op_reg;
        sts.still = (mag_f < {17'd0, cfg.position_dead_band})
                    && (mag_l < {17'd0, cfg.position_dead_band})
                    && (mag_h < {1'b0, cfg.heading_dead_band});
    end

    always_comb
    begin
        mul_a    = cmd.mul_l ? l_reg : f_reg;
        prod     = mul_a * GAIN_Q31;
        prod_rnd = prod + 64'sd16384;
        gained   = prod_rnd[63:15];
    end

    always_comb
    begin
        hq       = wh_reg & ANGLE_MASK;
        q        = 2'((hq + 32'h2000_0000) >> 30);
        u        = hq - {q, 30'd0};
        sx       = x_reg >>> cmd.step;
        sy       = y_reg >>> cmd.step;
        step_ang = $signed({{(ANG_W - 30){1'b0}}, atan_turns(5'(cmd.step))});
    end

    always_comb
    begin
        rx    = (x_reg + ROT_W'(32768)) >>> 16;
        ry    = (y_reg + ROT_W'(32768)) >>> 16;
        sum_x = ACC_W'(wx_reg) + ACC_W'(rx);
        sum_y = ACC_W'(wy_reg) + ACC_W'(ry);
        ovf_x = (sum_x[ACC_W-1:POS_W-1] != {(ACC_W - POS_W + 1){sum_x[ACC_W-1]}});
        ovf_y = (sum_y[ACC_W-1:POS_W-1] != {(ACC_W - POS_W + 1){sum_y[ACC_W-1]}});
        if (ovf_x)
        begin
            cl_x = sum_x[ACC_W-1] ? {1'b1, {(POS_W - 1){1'b0}}} : {1'b0, {(POS_W - 1){1'b1}}};
        end
        else
        begin
            cl_x = sum_x[POS_W-1:0];
        end
        if (ovf_y)
        begin
            cl_y = sum_y[ACC_W-1] ? {1'b1, {(POS_W - 1){1'b0}}} : {1'b0, {(POS_W - 1){1'b1}}};
        end
        else
        begin
            cl_y = sum_y[POS_W-1:0];
        end
    end

    always_comb
    begin
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        wx_next    = wx_reg;
        wy_next    = wy_reg;
        wh_next    = wh_reg;
        moved_next = moved_reg;
        sat_next   = sat_reg;
        if (cmd.latch)
        begin
            moved_next = 1'b0;
            sat_next   = 1'b0;
        end
        if (cmd.load_start)
        begin
            wx_next = POS_W'(cfg.start_x);
            wy_next = POS_W'(cfg.start_y);
            wh_next = cfg.start_heading;
        end
        if (cmd.head)
        begin
            wh_next    = wh_reg + dh_reg;
            moved_next = 1'b1;
        end
        if (cmd.mul_f)
        begin
            x_next = gained;
        end
        if (cmd.mul_l)
        begin
            y_next = gained;
        end
        if (cmd.quad)
        begin
            z_next = ANG_W'($signed(u));
            unique case (q)
                2'd0:
                begin
                    x_next = x_reg;
                    y_next = y_reg;
                end
                2'd1:
                begin
                    x_next = -y_reg;
                    y_next = x_reg;
                end
                2'd2:
                begin
                    x_next = -x_reg;
                    y_next = -y_reg;
                end
                2'd3:
                begin
                    x_next = y_reg;
                    y_next = -x_reg;
                end
                default:
                begin
                    x_next = x_reg;
                    y_next = y_reg;
                end
            endcase
        end
        if (cmd.rot)
        begin
            if (!z_reg[ANG_W-1])
            begin
                x_next = x_reg - sy;
                y_next = y_reg + sx;
                z_next = z_reg - step_ang;
            end
            else
            begin
                x_next = x_reg + sy;
                y_next = y_reg - sx;
                z_next = z_reg + step_ang;
            end
        end
        if (cmd.acc)
        begin
            wx_next  = cl_x;
            wy_next  = cl_y;
            sat_next = ovf_x || ovf_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg <= in_op;
            f_reg  <= in_forward;
            l_reg  <= in_lateral;
            dh_reg <= in_heading;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wx_reg    <= '0;
            wy_reg    <= '0;
            wh_reg    <= '0;
            moved_reg <= 1'b0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            wx_reg    <= wx_next;
            wy_reg    <= wy_next;
            wh_reg    <= wh_next;
            moved_reg <= moved_next;
            sat_reg   <= sat_next;
        end
    end

    assign pose_x       = wx_reg;
    assign pose_y       = wy_reg;
    assign pose_heading = wh_reg;
    assign moved        = moved_reg;
    assign saturated    = sat_reg;

endmodule

`default_nettype wire
